// ----- rtl/lfg_pkg.sv -----
// Shared types and constants for the lagged Fibonacci generator.
// No dependencies; imported by the controller, the datapath and the divider.
package lfg_pkg;

  localparam int TABLE_LEN = 56;
  localparam int FRAC_W    = 24;
  localparam int SEED_W    = 31;
  localparam int POS_W     = 6;
  localparam int BIT_CNT_W = 5;
  localparam int DIVD_W    = 31;   // widest dividend: seed
  localparam int DIVS_W    = 15;   // widest divisor: 30082
  localparam int RECIP_W   = 32;   // widest reciprocal: for divide by 100

  localparam logic [SEED_W-1:0] SEED_RESET = 31'd12345;
  localparam logic [SEED_W-1:0] BIG_SEED   = 31'd900000000;
  localparam logic [POS_W-1:0]  LAST_ENT   = 6'd55;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd23;

  // divider operation: selects operands and where the result lands
  typedef enum logic [3:0] {
    DS_SCALE, DS_IJ, DS_B, DS_A, DS_D, DS_C, DS_M1, DS_M2, DS_DN
  } lfg_dsel_t;

  typedef enum logic [1:0] {
    EM_NONE, EM_INIT, EM_DRAW, EM_NRDY
  } lfg_emit_t;

  typedef struct packed {
    logic             latch;      // capture seed and range limit
    logic             div_go;
    logic             div_store;
    lfg_dsel_t        dsel;
    logic             bit_shift;  // shift one seeding bit into the accumulator
    logic             ent_wr;     // write accumulator to table entry ent
    logic [POS_W-1:0] ent;
    logic             rd_hi;      // read taps 24/55 instead of 8/16
    logic             tap_pair;   // register sum of first tap pair
    logic             tap_sum;    // finish sum, write back, move pointer
    logic             mul_lo;
    logic             mul_hi;
    logic             prod_add;
    lfg_emit_t        emit;
  } lfg_cmd_t;

  typedef struct packed {
    logic s_big;
    logic div_done;
  } lfg_sts_t;

endpackage

// ----- rtl/lfg_div.sv -----
// Constant divider shared by all seeding steps: reciprocal multiply, then remainder.
// Uses lfg_pkg widths and divide selects; quotient and remainder are ready when done is raised.
module lfg_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  lfg_pkg::lfg_dsel_t           dsel,
  input  logic [lfg_pkg::DIVD_W-1:0]   dividend,
  output logic                         done,
  output logic [lfg_pkg::DIVD_W-1:0]   quo,
  output logic [lfg_pkg::DIVS_W-1:0]   rem
);
  import lfg_pkg::*;

  localparam int PROD_W = DIVD_W + RECIP_W;

  logic [DIVD_W-1:0]  x_r;
  lfg_dsel_t          sel_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DIVD_W-1:0]  q_r;
  logic [DIVS_W-1:0]  rem_r;
  logic [2:0]         stage_r;  // product, quotient, remainder
  logic               done_r;

  logic [RECIP_W-1:0] rcp;
  logic [DIVS_W-1:0]  dvs;
  logic [DIVD_W-1:0]  q;
  logic [DIVS_W-1:0]  qd;

  // floor(x/d) = (x * ceil(2^k/d)) >> k, exact over each dividend's range:
  // k = 38 for the seed scaling, 45 for the seed split, 23 for the small divisors
  always_comb begin
    case (sel_r)
      DS_SCALE:     begin rcp = 32'd2748779070; dvs = 15'd100;   end
      DS_IJ:        begin rcp = 32'd1169615455; dvs = 15'd30082; end
      DS_B, DS_A:   begin rcp = 32'd47394;      dvs = 15'd177;   end
      DS_D, DS_DN:  begin rcp = 32'd49637;      dvs = 15'd169;   end
      DS_C:         begin rcp = 32'd47128;      dvs = 15'd178;   end
      DS_M1, DS_M2: begin rcp = 32'd46864;      dvs = 15'd179;   end
      default:      begin rcp = 32'd47394;      dvs = 15'd177;   end
    endcase
    case (sel_r)
      DS_SCALE: q = DIVD_W'(prod_r >> 38);
      DS_IJ:    q = DIVD_W'(prod_r >> 45);
      default:  q = DIVD_W'(prod_r >> 23);
    endcase
    // remainder is below 2^15, so low bits of q*d suffice
    qd = DIVS_W'(q_r * dvs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], go};
      done_r  <= stage_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r   <= dividend;
      sel_r <= dsel;
    end
    if (stage_r[0]) prod_r <= x_r * rcp;
    if (stage_r[1]) q_r    <= q;
    if (stage_r[2]) rem_r  <= x_r[DIVS_W-1:0] - qd;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/lfg_dp.sv -----
// Datapath: lag table memory, seeding registers, tap adder and draw scaling.
// Depends on lfg_pkg and lfg_div; driven by lfg_ctrl commands.
module lfg_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfg_pkg::lfg_cmd_t           cmd,
  output lfg_pkg::lfg_sts_t           sts,
  input  logic [lfg_pkg::SEED_W-1:0]  seed,
  input  logic [lfg_pkg::SEED_W-1:0]  range_limit,
  output logic [lfg_pkg::FRAC_W-1:0]  fraction,
  output logic [lfg_pkg::SEED_W-1:0]  drawn_integer,
  output logic [lfg_pkg::SEED_W-1:0]  seed_value,
  output logic                        not_ready
);
  import lfg_pkg::*;

  localparam logic [POS_W:0] OFF_A = 7'd8;
  localparam logic [POS_W:0] OFF_B = 7'd16;
  localparam logic [POS_W:0] OFF_C = 7'd24;
  localparam logic [POS_W:0] LEN   = 7'd56;

  logic [FRAC_W-1:0] mem [TABLE_LEN];

  logic [SEED_W-1:0] s_r;
  logic [SEED_W-1:0] n_r;
  logic [16:0]       ij_r;
  logic [14:0]       kl_r;
  logic [16:0]       t_r;
  logic [7:0]        a_r, b_r, c_r, d_r, m1_r;
  logic [FRAC_W-1:0] acc_r;
  logic [POS_W-1:0]  pos_r;
  logic [FRAC_W-1:0] rd0_r, rd1_r, pair_r, f_r;
  logic [39:0]       plo_r;
  logic [38:0]       phi_r;
  logic [SEED_W-1:0] hi_r;
  logic [FRAC_W-1:0] frac_r;
  logic [SEED_W-1:0] drawn_r, seedv_r;
  logic              nrdy_r;

  logic [DIVD_W-1:0] divd;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic              div_done;
  logic [SEED_W-1:0] scl;
  logic [15:0]       ab, m1c, dc;
  logic [13:0]       dn;
  logic [POS_W-1:0]  addr0, addr1;
  logic [FRAC_W-1:0] f_nxt;
  logic [54:0]       psum;
  logic [SEED_W:0]   drawn1;

  function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] p,
                                                input logic [POS_W:0]   off);
    logic [POS_W:0] s;
    s = {1'b0, p} + off;
    if (s >= LEN) s = s - LEN;
    return s[POS_W-1:0];
  endfunction

  always_comb begin
    ab  = a_r * b_r;
    m1c = m1_r * c_r;
    dc  = d_r * c_r;
    dn  = 14'(d_r * 14'd53) + 14'd1;
    // floor(41*s/100) from s = 100*q + r: 41*q + floor(41*r/100)
    scl = SEED_W'(quo[24:0] * 31'd41) + SEED_W'((rem[6:0] * 26'd429926) >> 20);
    divd = s_r;
    case (cmd.dsel)
      DS_SCALE: divd = s_r;
      DS_IJ:    divd = s_r;
      DS_B:     divd = DIVD_W'(ij_r);
      DS_A:     divd = DIVD_W'(t_r);
      DS_D:     divd = DIVD_W'(kl_r);
      DS_C:     divd = DIVD_W'(t_r);
      DS_M1:    divd = DIVD_W'(ab);
      DS_M2:    divd = DIVD_W'(m1c);
      DS_DN:    divd = DIVD_W'(dn);
      default:  divd = s_r;
    endcase
  end

  lfg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dsel     (cmd.dsel),
    .dividend (divd),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  assign sts.s_big    = (s_r > BIG_SEED);
  assign sts.div_done = div_done;

  // seeding registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      s_r <= seed;
      n_r <= range_limit;
    end
    if (cmd.div_store) begin
      case (cmd.dsel)
        DS_SCALE: s_r <= scl;
        DS_IJ: begin
          ij_r <= quo[16:0];
          kl_r <= rem;
        end
        DS_B: begin
          t_r <= quo[16:0];
          b_r <= rem[7:0] + 8'd2;
        end
        DS_A: a_r <= rem[7:0] + 8'd2;
        DS_D: begin
          t_r <= quo[16:0];
          d_r <= rem[7:0];
        end
        DS_C:  c_r  <= rem[7:0] + 8'd1;
        DS_M1: m1_r <= rem[7:0];
        DS_M2: begin
          a_r <= b_r;
          b_r <= c_r;
          c_r <= rem[7:0];
        end
        DS_DN: d_r <= rem[7:0];
        default: ;
      endcase
    end
    // bit is decided by bit 5 of d*m, m now sitting in c
    if (cmd.bit_shift) acc_r <= {acc_r[FRAC_W-2:0], dc[5]};
  end

  // table taps
  always_comb begin
    addr0 = cmd.rd_hi ? wrap_add(pos_r, OFF_C) : wrap_add(pos_r, OFF_A);
    addr1 = cmd.rd_hi ? ((pos_r == '0) ? LAST_ENT : pos_r - 1'b1)
                      : wrap_add(pos_r, OFF_B);
    f_nxt = pair_r + rd0_r + rd1_r;
  end

  always_ff @(posedge clk) begin
    rd0_r <= mem[addr0];
    rd1_r <= mem[addr1];
    if (cmd.ent_wr) mem[cmd.ent] <= acc_r;
    else if (cmd.tap_sum) mem[pos_r] <= f_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.emit == EM_INIT) begin
      pos_r <= '0;
    end else if (cmd.tap_sum) begin
      pos_r <= (pos_r == '0) ? LAST_ENT : pos_r - 1'b1;
    end
  end

  // draw scaling: f*n split into two partial products
  always_comb begin
    psum   = {15'b0, plo_r} + {phi_r, 16'b0};
    drawn1 = {1'b0, hi_r} + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_pair) pair_r <= rd0_r + rd1_r;
    if (cmd.tap_sum)  f_r    <= f_nxt;
    if (cmd.mul_lo)   plo_r  <= f_r * n_r[15:0];
    if (cmd.mul_hi)   phi_r  <= f_r * n_r[30:16];
    if (cmd.prod_add) hi_r   <= psum[54:24];
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_INIT: begin
        frac_r  <= '0;
        drawn_r <= '0;
        seedv_r <= s_r;
        nrdy_r  <= 1'b0;
      end
      EM_DRAW: begin
        frac_r  <= f_r;
        drawn_r <= (drawn1 > {1'b0, n_r}) ? n_r : drawn1[SEED_W-1:0];
        // floor(f * (2^31 - 1) / 2^24) = f*128 - 1 for nonzero f
        seedv_r <= (f_r == '0) ? '0 : {f_r, 7'b0} - 31'd1;
        nrdy_r  <= 1'b0;
      end
      EM_NRDY: begin
        frac_r  <= '0;
        drawn_r <= '0;
        seedv_r <= '0;
        nrdy_r  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign fraction      = frac_r;
  assign drawn_integer = drawn_r;
  assign seed_value    = seedv_r;
  assign not_ready     = nrdy_r;

endmodule

// ----- rtl/lfg_ctrl.sv -----
// Controller state machine: sequences seeding and draws, issues datapath commands.
// Depends on lfg_pkg.
module lfg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              opcode,
  input  lfg_pkg::lfg_sts_t sts,
  output lfg_pkg::lfg_cmd_t cmd,
  output logic              busy,
  output logic              strobe
);
  import lfg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_DGO, S_DWAIT, S_BIT, S_WRITE,
    S_RD_A, S_RD_B, S_SUM, S_MLO, S_MHI, S_ADD,
    S_EM_DRAW, S_EM_INIT, S_EM_NRDY
  } state_t;

  localparam logic OP_INIT = 1'b0;

  state_t                state_r, state_nxt;
  lfg_dsel_t             dsel_r, dsel_nxt;
  logic [BIT_CNT_W-1:0]  bit_r, bit_nxt;
  logic [POS_W-1:0]      ent_r, ent_nxt;
  logic                  initd_r, initd_nxt;
  logic                  strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    dsel_nxt   = dsel_r;
    bit_nxt    = bit_r;
    ent_nxt    = ent_r;
    initd_nxt  = initd_r;
    strobe_nxt = 1'b0;
    cmd        = '0;
    cmd.dsel   = dsel_r;
    cmd.ent    = ent_r;
    cmd.emit   = EM_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (opcode == OP_INIT) state_nxt = S_INIT;
          else if (initd_r)      state_nxt = S_RD_A;
          else                   state_nxt = S_EM_NRDY;
        end
      end
      S_INIT: begin
        bit_nxt   = '0;
        ent_nxt   = '0;
        dsel_nxt  = sts.s_big ? DS_SCALE : DS_IJ;
        state_nxt = S_DGO;
      end
      S_DGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DGO;
          case (dsel_r)
            DS_SCALE: dsel_nxt = DS_IJ;
            DS_IJ:    dsel_nxt = DS_B;
            DS_B:     dsel_nxt = DS_A;
            DS_A:     dsel_nxt = DS_D;
            DS_D:     dsel_nxt = DS_C;
            DS_C:     dsel_nxt = DS_M1;
            DS_M1:    dsel_nxt = DS_M2;
            DS_M2:    dsel_nxt = DS_DN;
            DS_DN:    state_nxt = S_BIT;
            default:  dsel_nxt = DS_M1;
          endcase
        end
      end
      S_BIT: begin
        cmd.bit_shift = 1'b1;
        dsel_nxt      = DS_M1;
        if (bit_r == LAST_BIT) begin
          bit_nxt   = '0;
          state_nxt = S_WRITE;
        end else begin
          bit_nxt   = bit_r + 1'b1;
          state_nxt = S_DGO;
        end
      end
      S_WRITE: begin
        cmd.ent_wr = 1'b1;
        if (ent_r == LAST_ENT) begin
          state_nxt = S_EM_INIT;
        end else begin
          ent_nxt   = ent_r + 1'b1;
          state_nxt = S_DGO;
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        cmd.rd_hi    = 1'b1;
        cmd.tap_pair = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.tap_sum = 1'b1;
        state_nxt   = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.prod_add = 1'b1;
        state_nxt    = S_EM_DRAW;
      end
      S_EM_DRAW: begin
        cmd.emit   = EM_DRAW;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_EM_INIT: begin
        cmd.emit   = EM_INIT;
        initd_nxt  = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_EM_NRDY: begin
        cmd.emit   = EM_NRDY;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dsel_r   <= DS_IJ;
      bit_r    <= '0;
      ent_r    <= '0;
      initd_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dsel_r   <= dsel_nxt;
      bit_r    <= bit_nxt;
      ent_r    <= ent_nxt;
      initd_r  <= initd_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign strobe = strobe_r;

endmodule

// ----- rtl/lagged_fibonacci_random_generator_top.sv -----
// Top level of the lagged Fibonacci generator: seed register, controller, datapath.
// Depends on lfg_pkg, lfg_ctrl, lfg_dp (and lfg_div below it).
//
//   channel  handshake                          payload
//   input    start, busy (taken: start & !busy) in_opcode, in_range_limit
//   result   out_strobe (one cycle, no stall)   out_fraction, out_drawn_integer,
//                                               out_seed_value, out_not_ready
//   config   psel, penable, pwrite, pready      paddr, pwdata, prdata (seed at 0)
//
// A draw runs from the accepting cycle to the strobe cycle through two table
// reads on the two-port lag table, the tap add, two partial products of f*n.
// A draw before initialise goes straight to a not-ready result.
// Initialise is paced by the shared reciprocal divider (one more divide for seeds
// above 900000000), with three divides per table bit.
// start is taken again in the strobe cycle. Reset is synchronous, active low;
// the table is not cleared and the receiver cannot stall results.
module lagged_fibonacci_random_generator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [lfg_pkg::SEED_W-1:0]  in_range_limit,
  output logic                        out_strobe,
  output logic [lfg_pkg::FRAC_W-1:0]  out_fraction,
  output logic [lfg_pkg::SEED_W-1:0]  out_drawn_integer,
  output logic [lfg_pkg::SEED_W-1:0]  out_seed_value,
  output logic                        out_not_ready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lfg_pkg::*;

  localparam logic [1:0] ADDR_SEED = 2'd0;

  logic [SEED_W-1:0] seed_r;
  lfg_cmd_t          cmd;
  lfg_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_SEED) begin
      seed_r <= pwdata[SEED_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SEED) ? {1'b0, seed_r} : 32'd0;

  lfg_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (out_strobe)
  );

  lfg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .seed          (seed_r),
    .range_limit   (in_range_limit),
    .fraction      (out_fraction),
    .drawn_integer (out_drawn_integer),
    .seed_value    (out_seed_value),
    .not_ready     (out_not_ready)
  );

  // a result only appears once the controller is back to taking items
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("more than one result for an item");

  a_nrdy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_not_ready) |-> (out_fraction == '0 && out_seed_value == '0))
    else $error("not-ready result carries data");

endmodule

// ----- tb/lfg_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the lagged Fibonacci generator: mirrors seed writes, predicts each item.
// Depends on lfg_pkg for widths and the large-seed bound; instantiated by the testbench top.
module lfg_checker #(
  parameter logic [1:0] SEED_ADDR = '0,
  parameter logic       OP_INIT   = 1'b0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        in_opcode,
  input  logic [lfg_pkg::SEED_W-1:0]  in_range_limit,
  input  logic                        out_strobe,
  input  logic [lfg_pkg::FRAC_W-1:0]  out_fraction,
  input  logic [lfg_pkg::SEED_W-1:0]  out_drawn_integer,
  input  logic [lfg_pkg::SEED_W-1:0]  out_seed_value,
  input  logic                        out_not_ready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output int unsigned                 results_seen,
  output int unsigned                 mismatches
);
  import lfg_pkg::*;

  localparam int unsigned IJ_DIV   = 30082;
  localparam int unsigned MOD_AB   = 177;
  localparam int unsigned MOD_C    = 178;
  localparam int unsigned MOD_KL   = 169;
  localparam int unsigned MOD_M    = 179;
  localparam int unsigned MULT_D   = 53;
  localparam int unsigned BIT_MOD  = 64;
  localparam int unsigned BIT_HALF = 32;
  localparam longint unsigned SCALE_MAX = 64'd2147483647;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic [SEED_W-1:0] drawn;
    logic [SEED_W-1:0] scaled;
    logic              not_ready;
  } lfg_result_t;

  logic [FRAC_W-1:0] lag_tab [TABLE_LEN];
  int unsigned       wr_pos;
  bit                seeded;
  logic [SEED_W-1:0] seed_reg;
  lfg_result_t       predicted_results [$];
  int unsigned       seen_cnt = 0;
  int unsigned       mismatch_cnt = 0;

  assign results_seen = seen_cnt;
  assign mismatches   = mismatch_cnt;

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    mismatch_cnt++;
  endtask

  // Marsaglia seeding of the whole table; returns the seed actually used
  function automatic logic [SEED_W-1:0] fill_lag_table();
    int unsigned s, ij, kl, a, b, c, d, m, acc;
    s = seed_reg;
    if (s > BIG_SEED) s = int'((longint'(s) * 41) / 100);
    ij = s / IJ_DIV;
    kl = s - IJ_DIV * ij;
    a = (ij / MOD_AB) % MOD_AB + 2;
    b = ij % MOD_AB + 2;
    c = (kl / MOD_KL) % MOD_C + 1;
    d = kl % MOD_KL;
    for (int e = 0; e < TABLE_LEN; e++) begin
      acc = 0;
      for (int k = 0; k < FRAC_W; k++) begin
        m = ((a * b) % MOD_M) * c % MOD_M;
        a = b;
        b = c;
        c = m;
        d = (MULT_D * d + 1) % MOD_KL;
        acc = (acc << 1) | (((d * m) % BIT_MOD >= BIT_HALF) ? 1 : 0);
      end
      lag_tab[e] = acc[FRAC_W-1:0];
    end
    wr_pos = 0;
    seeded = 1'b1;
    return s[SEED_W-1:0];
  endfunction

  function automatic lfg_result_t next_number(input logic [SEED_W-1:0] n);
    lfg_result_t r;
    logic [FRAC_W-1:0] f;
    longint unsigned drawn;
    f = lag_tab[(wr_pos + 8) % TABLE_LEN] + lag_tab[(wr_pos + 16) % TABLE_LEN]
      + lag_tab[(wr_pos + 24) % TABLE_LEN] + lag_tab[(wr_pos + 55) % TABLE_LEN];
    lag_tab[wr_pos] = f;
    wr_pos = (wr_pos == 0) ? TABLE_LEN - 1 : wr_pos - 1;
    drawn = ((longint'(f) * longint'(n)) >> FRAC_W) + 1;
    if (drawn > n) drawn = n;
    r.fraction  = f;
    r.drawn     = drawn[SEED_W-1:0];
    r.scaled    = SEED_W'((longint'(f) * SCALE_MAX) >> FRAC_W);
    r.not_ready = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    lfg_result_t want;
    if (!rst_n) begin
      foreach (lag_tab[i]) lag_tab[i] = '0;
      wr_pos   = 0;
      seeded   = 1'b0;
      seed_reg = SEED_RESET;
      predicted_results.delete();
    end else begin
      // a result can land on the same edge that takes the next item: pop first
      if (out_strobe) begin
        seen_cnt <= seen_cnt + 1;
        if (predicted_results.size() == 0) begin
          $display("[%0t] result with no item outstanding", $time);
          mismatch_cnt++;
        end else begin
          want = predicted_results.pop_front();
          if (out_fraction !== want.fraction)
            report_mismatch("fraction", want.fraction, out_fraction);
          if (out_drawn_integer !== want.drawn)
            report_mismatch("drawn_integer", want.drawn, out_drawn_integer);
          if (out_seed_value !== want.scaled)
            report_mismatch("seed_value", want.scaled, out_seed_value);
          if (out_not_ready !== want.not_ready)
            report_mismatch("not_ready", want.not_ready, out_not_ready);
        end
      end
      if (start && !busy) begin
        if (in_opcode == OP_INIT) begin
          want = '0;
          want.scaled = fill_lag_table();
        end else if (!seeded) begin
          want = '0;
          want.not_ready = 1'b1;
        end else begin
          want = next_number(in_range_limit);
        end
        predicted_results.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
        seed_reg = pwdata[SEED_W-1:0];
    end
  end

endmodule

// ----- tb/tb_lagged_fibonacci_random_generator_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the lagged Fibonacci generator: clock, reset, items, seed writes, verdict.
// Depends on lfg_pkg, lagged_fibonacci_random_generator_top and lfg_checker.
module tb_lagged_fibonacci_random_generator_top;
  import lfg_pkg::*;

  localparam logic [1:0]        SEED_ADDR   = 2'd0;
  localparam logic              OP_INIT     = 1'b0;
  localparam logic              OP_DRAW     = 1'b1;
  localparam logic [SEED_W-1:0] LIMIT_MAX   = '1;
  localparam int unsigned       CYCLE_LIMIT = 2_500_000;
  localparam int unsigned       PHASE_DRAWS = 444;
  localparam int unsigned       DRAIN       = 20;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_opcode;
  logic [SEED_W-1:0] in_range_limit;
  logic              out_strobe;
  logic [FRAC_W-1:0] out_fraction;
  logic [SEED_W-1:0] out_drawn_integer;
  logic [SEED_W-1:0] out_seed_value;
  logic              out_not_ready;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [1:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned inits_sent = 0;
  int unsigned seed_writes = 0;
  bit          no_idle = 1'b0;

  logic [31:0] phase_seeds [3];

  always #5 clk = ~clk;

  lagged_fibonacci_random_generator_top DUT (.*);

  lfg_checker #(.SEED_ADDR(SEED_ADDR), .OP_INIT(OP_INIT)) u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lagged_fibonacci_random_generator_top regression: fail");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (no_idle) return 0;
    if (roll < 5) return 0;
    if (roll < 17) return $urandom_range(1, 12);
    return $urandom_range(13, 60);
  endfunction

  function automatic logic [SEED_W-1:0] pick_limit();
    logic [SEED_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = SEED_W'($urandom_range(1, 16));
      1: v = ($urandom_range(0, 1) != 0) ? LIMIT_MAX : '0;
      2: v = SEED_W'(1) << $urandom_range(0, SEED_W - 1);
      3: v = (SEED_W'(1) << $urandom_range(1, SEED_W - 1)) - 1'b1;
      default: v = SEED_W'($urandom());
    endcase
    return v;
  endfunction

  // start stays high across back-to-back items
  task automatic send_item(input logic op, input logic [SEED_W-1:0] limit);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_range_limit <= limit;
    do @(posedge clk); while (busy);
    items_sent++;
    if (op == OP_INIT) inits_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    wait_drained();
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    seed_writes++;
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= OP_DRAW;
    in_range_limit <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= SEED_ADDR;
    pwdata         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // draws before any initialise are flagged
    send_item(OP_DRAW, 31'd7);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, LIMIT_MAX);
    // reset seed, range extremes and alternating bit patterns
    send_item(OP_INIT, pick_limit());
    send_item(OP_DRAW, 31'd1);
    send_item(OP_DRAW, '0);
    send_item(OP_DRAW, LIMIT_MAX);
    send_item(OP_DRAW, 31'd2);
    send_item(OP_DRAW, 31'h5555_5555);
    send_item(OP_DRAW, 31'h2AAA_AAAA);
    send_item(OP_DRAW, 31'h4000_0000);
    // reseed from the same value restarts the sequence
    send_item(OP_INIT, LIMIT_MAX);
    send_item(OP_DRAW, LIMIT_MAX);
    write_seed(32'd0);
    send_item(OP_INIT, '0);
    send_item(OP_DRAW, 31'd1);
    // all ones, bit 31 dropped by the register; large-seed rule applies
    write_seed(32'hFFFF_FFFF);
    send_item(OP_INIT, pick_limit());
    send_item(OP_DRAW, LIMIT_MAX);

    // either side of the large-seed bound, then a random seed
    phase_seeds[0] = 32'd900000000;
    phase_seeds[1] = 32'd900000001;
    phase_seeds[2] = $urandom();
    foreach (phase_seeds[p]) begin
      write_seed(phase_seeds[p]);
      send_item(OP_INIT, pick_limit());
      for (int k = 0; k < PHASE_DRAWS; k++) begin
        if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_item(OP_DRAW, pick_limit());
      end
      no_idle = 1'b0;
    end

    wait_drained();
    repeat (DRAIN) @(posedge clk);
    $display("covered %0d items (%0d initialise, %0d draw) over %0d seed writes",
             items_sent, inits_sent, items_sent - inits_sent, seed_writes);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && results_seen == items_sent) begin
      $display("lagged_fibonacci_random_generator_top regression: pass");
    end else begin
      $display("lagged_fibonacci_random_generator_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lfg_pkg.sv
rtl/lfg_div.sv
rtl/lfg_dp.sv
rtl/lfg_ctrl.sv
rtl/lagged_fibonacci_random_generator_top.sv
tb/lfg_checker.sv
tb/tb_lagged_fibonacci_random_generator_top.sv
